FILE: hw/rtl/sfrs_pkg.sv
package sfrs_pkg;

   localparam int MaxRows     = 24;
   localparam int RowWidth    = 5;
   localparam int ColWidth    = 7;
   localparam int DataCols    = 110;
   localparam int TotalCols   = 120;
   localparam int NumPar      = 10;
   localparam int ParIdxWidth = 4;
   localparam int ResetRows   = 8;
   localparam int CsrWidth    = 5;

   localparam logic [8:0] GfPoly = 9'h11d;

   localparam logic REQ_DATA   = 1'b0;
   localparam logic REQ_PARITY = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_SEQ_ERR = 1'b1;

   typedef logic [7:0] gf_type;
   typedef logic [NumPar:0][7:0] gen_type;
   typedef logic [NumPar-1:0][7:0] rem_type;

   typedef struct packed {
      logic   req_type;
      gf_type data_byte;
   } req_word_type;

   typedef struct packed {
      gf_type out_byte;
      logic   is_parity;
      logic   frame_last;
      logic   status;
   } rsp_word_type;

   typedef struct packed {
      logic [RowWidth-1:0]    row;
      logic                   col_zero;
      logic [ParIdxWidth-1:0] par_idx;
      logic                   data_ok;
      logic                   par_ok;
      logic                   frame_last;
   } pos_type;

   function automatic gf_type gf_mul(gf_type a, gf_type b);
      logic [8:0] x;
      gf_type     acc;
      x   = {1'b0, a};
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x[7:0];
         end
         x = {x[7:0], 1'b0};
         if (x[8]) begin
            x = x ^ GfPoly;
         end
      end
      return acc;
   endfunction

   function automatic gen_type make_gen();
      gen_type g;
      gf_type  root;
      g    = '0;
      g[0] = 8'd1;
      root = 8'd1;
      for (int i = 0; i < NumPar; i++) begin
         for (int k = i + 1; k > 0; k--) begin
            g[k] = g[k-1] ^ gf_mul(root, g[k]);
         end
         g[0] = gf_mul(root, g[0]);
         root = gf_mul(root, 8'd2);
      end
      return g;
   endfunction

   localparam gen_type Gen = make_gen();

endpackage

FILE: hw/rtl/superframe_rs_120_110_encoder_top.sv
// Outer RS(120,110) coder for a byte-interleaved superframe of S rows.
// The req channel carries one word per byte: a data byte (req_type 0) or a
// request for the next parity byte (req_type 1). The rsp channel returns one
// word for every req word: the data byte passed through, a parity byte with
// is_parity set, and frame_last set on the final parity byte of the frame.
// A word out of sequence returns status 1 with a zero byte and changes
// nothing. The csr channel sets the row count S; a write restarts the frame
// and must only be issued while the block is idle; nothing enforces it.
// A taken word waits in the input register until the output register is
// free or being drained, then is registered there and raises rsp_valid.
// One word is taken per cycle unless rsp_ready stalls the output; a row's
// remainder update is a single pass of constant GF(256) multiplies.
// When rsp_ready is low the output register holds its word and the input
// register can still take one more word before req_ready drops.
// Reset sets S to 8, empties both registers and restarts the frame; row
// remainders are cleared as each row sees its first byte.
module superframe_rs_120_110_encoder_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sfrs_pkg::req_word_type        req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sfrs_pkg::rsp_word_type        rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfrs_pkg::CsrWidth-1:0] csr_data
);
   import sfrs_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         advance;
   pos_type      pos;
   gf_type       parity_byte;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_word_ff;

   sfrs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .step      (advance),
      .step_kind (in_word_ff.req_type),
      .pos       (pos)
   );

   sfrs_rem u_rem (
      .clock       (clock),
      .step        (advance),
      .pos         (pos),
      .data_byte   (in_word_ff.data_byte),
      .parity_byte (parity_byte)
   );

   always_comb begin
      rsp_word_in = '0;
      priority if (pos.data_ok) begin
         rsp_word_in.out_byte = in_word_ff.data_byte;
         rsp_word_in.status   = STATUS_OK;
      end else if (pos.par_ok) begin
         rsp_word_in.out_byte   = parity_byte;
         rsp_word_in.is_parity  = 1'b1;
         rsp_word_in.frame_last = pos.frame_last;
         rsp_word_in.status     = STATUS_OK;
      end else begin
         rsp_word_in.status = STATUS_SEQ_ERR;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_payload;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   a_err_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status == STATUS_SEQ_ERR |->
         rsp_word_ff.out_byte == '0 && !rsp_word_ff.is_parity && !rsp_word_ff.frame_last)
      else $error("error word carries data");
   a_last_is_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.frame_last |-> rsp_word_ff.is_parity)
      else $error("frame end on a data word");
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff) else $error("processed word lost");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("stalled word overwritten");

endmodule

FILE: hw/rtl/sfrs_seq.sv
module sfrs_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfrs_pkg::CsrWidth-1:0] csr_data,
   input  logic                          step,
   input  logic                          step_kind,
   output sfrs_pkg::pos_type             pos
);
   import sfrs_pkg::*;

   logic [RowWidth-1:0] rows_ff, rows_in;
   logic [RowWidth-1:0] row_ff, row_in;
   logic [ColWidth-1:0] col_ff, col_in;
   logic [RowWidth-1:0] last_row;
   logic [RowWidth-1:0] rows_clamped;
   logic [ColWidth-1:0] par_col;
   logic                row_end;

   assign csr_ready = 1'b1;
   assign last_row  = RowWidth'(rows_ff - RowWidth'(1));
   assign row_end   = (row_ff == last_row);
   assign par_col   = ColWidth'(col_ff - ColWidth'(DataCols));

   always_comb begin
      priority if (csr_data == '0) begin
         rows_clamped = RowWidth'(1);
      end else if (csr_data > CsrWidth'(MaxRows)) begin
         rows_clamped = RowWidth'(MaxRows);
      end else begin
         rows_clamped = RowWidth'(csr_data);
      end
   end

   always_comb begin
      pos.row        = row_ff;
      pos.col_zero   = (col_ff == '0);
      pos.par_idx    = par_col[ParIdxWidth-1:0];
      pos.data_ok    = (step_kind == REQ_DATA) && (col_ff < ColWidth'(DataCols));
      pos.par_ok     = (step_kind == REQ_PARITY) && (col_ff >= ColWidth'(DataCols));
      pos.frame_last = row_end && (col_ff == ColWidth'(TotalCols - 1));
   end

   always_comb begin
      rows_in = rows_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      priority if (csr_valid) begin
         rows_in = rows_clamped;
         row_in  = '0;
         col_in  = '0;
      end else if (step && (pos.data_ok || pos.par_ok)) begin
         if (row_end) begin
            row_in = '0;
            col_in = pos.frame_last ? '0 : ColWidth'(col_ff + ColWidth'(1));
         end else begin
            row_in = RowWidth'(row_ff + RowWidth'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RowWidth'(ResetRows);
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         rows_ff <= rows_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < rows_ff) else $error("row beyond row count");
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < ColWidth'(TotalCols)) else $error("column beyond frame");
   a_rows_valid: assert property (@(posedge clock) disable iff (reset)
      rows_ff != '0 && rows_ff <= RowWidth'(MaxRows)) else $error("bad row count");

endmodule

FILE: hw/rtl/sfrs_rem.sv
module sfrs_rem (
   input  logic              clock,
   input  logic              step,
   input  sfrs_pkg::pos_type pos,
   input  sfrs_pkg::gf_type  data_byte,
   output sfrs_pkg::gf_type  parity_byte
);
   import sfrs_pkg::*;

   rem_type rem_ff [MaxRows];
   rem_type cur;
   rem_type base;
   rem_type rem_in;
   gf_type  fb;

   assign cur         = rem_ff[pos.row];
   assign base        = pos.col_zero ? '0 : cur;
   assign fb          = data_byte ^ base[0];
   assign parity_byte = cur[pos.par_idx];

   always_comb begin
      for (int j = 1; j < NumPar; j++) begin
         rem_in[j-1] = base[j] ^ gf_mul(fb, Gen[NumPar-j]);
      end
      rem_in[NumPar-1] = gf_mul(fb, Gen[0]);
   end

   always_ff @(posedge clock) begin
      if (step && pos.data_ok) begin
         rem_ff[pos.row] <= rem_in;
      end
   end

endmodule

FILE: tb/superframe_rs_120_110_encoder_top_tb.sv
module superframe_rs_120_110_encoder_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfrs_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned PrintLimit = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrWidth-1:0] csr_data = '0;

   superframe_rs_120_110_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #5ns clock = ~clock;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   rsp_word_type want_word;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned words_queued = 0;
   int unsigned words_checked = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned frames_done = 0;
   int unsigned seq_errors = 0;
   int unsigned settings_used = 0;

   logic [CsrWidth-1:0] row_count_cfg = CsrWidth'(ResetRows);
   int unsigned frame_pos = 0;
   gf_type row_rem[MaxRows][NumPar];
   gf_type gen_coef[NumPar+1];

   function automatic gf_type gf_times(gf_type a, gf_type b);
      gf_type prod;
      gf_type shifted;
      prod = '0;
      shifted = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            prod = prod ^ shifted;
         end
         shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? GfPoly[7:0] : 8'h00);
      end
      return prod;
   endfunction

   function automatic int unsigned rows_in_use();
      if (row_count_cfg < 1) begin
         return 1;
      end else if (row_count_cfg > MaxRows) begin
         return MaxRows;
      end
      return 32'(row_count_cfg);
   endfunction

   // Computes the word returned for one accepted request and advances the
   // frame position and row remainders exactly as the coder does.
   function automatic rsp_word_type encode_word(req_word_type w);
      rsp_word_type r;
      int unsigned rows;
      int unsigned data_end;
      int unsigned frame_end;
      int unsigned pos;
      int unsigned row;
      int unsigned col;
      gf_type fb;
      r = '0;
      r.status = STATUS_OK;
      rows = rows_in_use();
      data_end = rows * DataCols;
      frame_end = rows * TotalCols;
      pos = (frame_pos >= frame_end) ? 0 : frame_pos;
      row = pos % rows;
      col = pos / rows;
      if (w.req_type == REQ_DATA) begin
         if (pos >= data_end) begin
            r.status = STATUS_SEQ_ERR;
            seq_errors++;
         end else begin
            if (col == 0) begin
               for (int j = 0; j < NumPar; j++) begin
                  row_rem[row][j] = '0;
               end
            end
            fb = w.data_byte ^ row_rem[row][0];
            for (int j = 1; j < NumPar; j++) begin
               row_rem[row][j-1] = row_rem[row][j] ^ gf_times(fb, gen_coef[NumPar-j]);
            end
            row_rem[row][NumPar-1] = gf_times(fb, gen_coef[0]);
            r.out_byte = w.data_byte;
            frame_pos = pos + 1;
         end
      end else begin
         if (pos < data_end) begin
            r.status = STATUS_SEQ_ERR;
            seq_errors++;
         end else begin
            r.out_byte = row_rem[row][(col - DataCols) % NumPar];
            r.is_parity = 1'b1;
            if (pos + 1 == frame_end) begin
               r.frame_last = 1'b1;
               frame_pos = 0;
               frames_done++;
            end else begin
               frame_pos = pos + 1;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= PrintLimit) begin
         $display("mismatch in %s at word %0d: got %0h, want %0h",
                  what, words_checked, got, want);
      end
   endtask

   function automatic void queue_word(logic kind, gf_type value);
      req_word_type w;
      w.req_type = kind;
      w.data_byte = value;
      pending_words.push_back(w);
      words_queued++;
   endfunction

   function automatic void queue_noise(logic kind, int unsigned noise_pct);
      if ($urandom_range(99) < noise_pct) begin
         queue_word(kind, gf_type'($urandom_range(255)));
      end
   endfunction

   // A well-formed superframe with random data, with the odd request of the
   // wrong kind mixed in; those come back as sequence errors.
   function automatic void queue_frame(int unsigned rows, int unsigned noise_pct);
      for (int unsigned a = 0; a < rows * DataCols; a++) begin
         queue_noise(REQ_PARITY, noise_pct);
         queue_word(REQ_DATA, gf_type'($urandom_range(255)));
      end
      for (int unsigned a = 0; a < rows * NumPar; a++) begin
         queue_noise(REQ_DATA, noise_pct);
         queue_word(REQ_PARITY, gf_type'($urandom_range(255)));
      end
   endfunction

   function automatic void queue_partial(int unsigned n_data, int unsigned noise_pct);
      for (int unsigned a = 0; a < n_data; a++) begin
         queue_noise(REQ_PARITY, noise_pct);
         queue_word(REQ_DATA, gf_type'($urandom_range(255)));
      end
      queue_word(REQ_PARITY, gf_type'($urandom_range(255)));
   endfunction

   task automatic wait_drained();
      do @(negedge clock); while (words_checked < words_queued);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_row_count(input logic [CsrWidth-1:0] value);
      @(posedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      row_count_cfg = value;
      frame_pos = 0;
      settings_used++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp.push_back(encode_word(req_payload));
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_rsp.size() == 0) begin
               report_mismatch("word with nothing expected", 32'(rsp_payload), 0);
            end else begin
               want_word = expected_rsp.pop_front();
               if (rsp_payload.out_byte !== want_word.out_byte) begin
                  report_mismatch("out_byte", 32'(rsp_payload.out_byte),
                                  32'(want_word.out_byte));
               end
               if (rsp_payload.is_parity !== want_word.is_parity) begin
                  report_mismatch("is_parity", 32'(rsp_payload.is_parity),
                                  32'(want_word.is_parity));
               end
               if (rsp_payload.frame_last !== want_word.frame_last) begin
                  report_mismatch("frame_last", 32'(rsp_payload.frame_last),
                                  32'(want_word.frame_last));
               end
               if (rsp_payload.status !== want_word.status) begin
                  report_mismatch("status", 32'(rsp_payload.status),
                                  32'(want_word.status));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles with %0d of %0d words returned",
                  cycle_count, words_checked, words_queued);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      gf_type root;
      gen_coef[0] = 8'd1;
      for (int i = 1; i <= NumPar; i++) begin
         gen_coef[i] = '0;
      end
      root = 8'd1;
      for (int i = 0; i < NumPar; i++) begin
         for (int k = i + 1; k > 0; k--) begin
            gen_coef[k] = gen_coef[k-1] ^ gf_times(root, gen_coef[k]);
         end
         gen_coef[0] = gf_times(root, gen_coef[0]);
         root = gf_times(root, 8'd2);
      end
      for (int r = 0; r < MaxRows; r++) begin
         for (int j = 0; j < NumPar; j++) begin
            row_rem[r][j] = '0;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Eight rows after reset: a parity request before any data, data
      // bytes at the extremes, and a parity request in the middle of data.
      queue_word(REQ_PARITY, 8'hff);
      queue_word(REQ_DATA, 8'h00);
      queue_word(REQ_DATA, 8'hff);
      queue_word(REQ_DATA, 8'h01);
      queue_word(REQ_DATA, 8'h80);
      queue_word(REQ_DATA, 8'h7f);
      queue_word(REQ_DATA, 8'hfe);
      queue_word(REQ_PARITY, 8'h00);
      queue_word(REQ_DATA, 8'h55);
      queue_word(REQ_DATA, 8'haa);
      wait_drained();

      // A row count of zero behaves as one row.
      write_row_count(5'd0);
      send_idle_pct = 76;
      queue_frame(rows_in_use(), 2);
      wait_drained();
      queue_frame(rows_in_use(), 2);
      wait_drained();

      write_row_count(5'd2);
      send_idle_pct = 0;
      stall_pct = 76;
      queue_frame(rows_in_use(), 2);
      wait_drained();

      // Above the maximum the row count saturates; the frame is cut short
      // and the next write restarts it.
      write_row_count(5'd31);
      send_idle_pct = 11;
      stall_pct = 11;
      queue_partial(5 * MaxRows + 3, 3);
      wait_drained();

      write_row_count(5'd24);
      send_idle_pct = 0;
      stall_pct = 0;
      queue_partial(60, 3);
      wait_drained();

      write_row_count(5'd3);
      queue_frame(rows_in_use(), 2);
      wait_drained();

      write_row_count(5'd1);
      send_idle_pct = 76;
      queue_frame(rows_in_use(), 3);
      queue_frame(rows_in_use(), 3);
      wait_drained();

      write_row_count(CsrWidth'($urandom_range(1, 2)));
      send_idle_pct = 0;
      stall_pct = 76;
      queue_frame(rows_in_use(), 2);
      wait_drained();

      if (expected_rsp.size() != 0) begin
         report_mismatch("words never returned", expected_rsp.size(), 0);
      end
      $display("Checked %0d words over %0d row-count settings and %0d cycles.",
               words_checked, settings_used, cycle_count);
      $display("Completed %0d superframes; %0d requests were out of sequence.",
               frames_done, seq_errors);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
